[src/appm_pkg.sv]
// Package for the averaged peak-to-peak meter.
// Holds register indexes, fixed widths, the back-end state type and queue status.
// No dependencies; imported by every module of the block.
package appm_pkg;

    localparam int FRAME_LEN_BITS = 13;
    localparam int FRAME_CNT_BITS = 8;
    localparam int FRAME_POS_BITS = 12;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 13;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [FRAME_LEN_BITS-1:0] FRAME_LEN_MAX = 13'd4096;
    localparam logic [FRAME_LEN_BITS-1:0] FRAME_LEN_RST = 13'd256;
    localparam logic [FRAME_CNT_BITS-1:0] FRAME_CNT_RST = 8'd10;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FRAME_LENGTH = 1'b0,
        CFG_FRAME_COUNT  = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        BK_ACCUM,
        BK_DIVIDE,
        BK_HOLD
    } t_back_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

[src/averaged_peak_to_peak_meter_core.sv]
// Top level of the averaged peak-to-peak meter.
// Depends on appm_pkg, appm_front, appm_queue and appm_back.
//
// Usage:
// Samples enter through a queue-style port: a sample is taken at a clock edge where
// push is high and full is low. The block groups samples into frames of frame_length
// samples, takes max minus min of each frame, and after frame_count frames places the
// truncated average of those peak-to-peak values on o_average_vpp. Results leave through
// a queue-style port: the result is valid while empty is low and is taken at an edge
// where pop is high and empty is low.
// Configuration is written through its own valid/ready channel (ready is always high);
// index 0 is frame_length, index 1 is frame_count. Write only while the block is idle.
// Throughput: one sample per cycle while full is low. The front end takes each accepted
// sample without stalling. The back end's bit-serial divider runs once per measurement;
// a four-entry queue of frame values absorbs that, so full rises when frames are so
// short that the queue fills during a division, or when the receiver stalls as
// described below.
// The last frame value passes through the queue and the divider into the result register.
// Reset clears the frame and measurement state and loads frame_length 256 and
// frame_count 10. If the receiver stalls, the finished result holds; the back end keeps
// summing frames and waits only when a second result is ready, after which the queue
// fills and full is raised.
module averaged_peak_to_peak_meter_core #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [SAMPLE_BITS-1:0]               i_sample,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [SAMPLE_BITS-1:0]               o_average_vpp,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [appm_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [appm_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import appm_pkg::*;

    logic [FRAME_LEN_BITS-1:0] r_frame_length;
    logic [FRAME_CNT_BITS-1:0] r_frame_count;
    logic                      sample_accept;
    logic                      vpp_push;
    logic [SAMPLE_BITS-1:0]    vpp_in;
    logic [SAMPLE_BITS-1:0]    vpp_out;
    logic                      vpp_pop;
    t_queue_stat               q_stat;

    // Configuration registers; the port never pushes back on a request.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length <= FRAME_LEN_RST;
            r_frame_count  <= FRAME_CNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_FRAME_LENGTH: r_frame_length <= i_cfg_data[FRAME_LEN_BITS-1:0];
                CFG_FRAME_COUNT:  r_frame_count  <= i_cfg_data[FRAME_CNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Any sample may close a frame, so a sample is refused whenever the queue is full.
    assign full          = q_stat.full;
    assign sample_accept = push && !q_stat.full;

    appm_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (sample_accept),
        .i_sample       (i_sample),
        .i_frame_length (r_frame_length),
        .o_vpp_push     (vpp_push),
        .o_vpp          (vpp_in)
    );

    appm_queue #(
        .WIDTH (SAMPLE_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (vpp_push),
        .i_data  (vpp_in),
        .i_pop   (vpp_pop),
        .o_data  (vpp_out),
        .o_stat  (q_stat)
    );

    appm_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_count (r_frame_count),
        .i_q_stat      (q_stat),
        .i_vpp         (vpp_out),
        .o_q_pop       (vpp_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_average_vpp (o_average_vpp)
    );

endmodule

[src/appm_queue.sv]
// Short flop-based queue that carries frame peak-to-peak values from front to back.
// Depends on appm_pkg for the depth and the status struct.
module appm_queue #(
    parameter int WIDTH = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [WIDTH-1:0]          i_data,
    input  logic                      i_pop,
    output logic [WIDTH-1:0]          o_data,
    output appm_pkg::t_queue_stat     o_stat
);
    import appm_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0]    r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_BITS:0]   r_count, n_count;
    logic                do_push, do_pop;

    // Push is only requested when not full, pop only when not empty.
    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == (PTR_BITS+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

[src/appm_front.sv]
// Front end: tracks the running minimum and maximum of each frame, one accepted sample
// per cycle. Emits the peak-to-peak value of every finished frame. Depends on appm_pkg.
module appm_front #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  logic [SAMPLE_BITS-1:0]               i_sample,
    input  logic [appm_pkg::FRAME_LEN_BITS-1:0]  i_frame_length,
    output logic                                 o_vpp_push,
    output logic [SAMPLE_BITS-1:0]               o_vpp
);
    import appm_pkg::*;

    logic [SAMPLE_BITS-1:0]    r_min, n_min;
    logic [SAMPLE_BITS-1:0]    r_max, n_max;
    logic [FRAME_POS_BITS-1:0] r_pos, n_pos;
    logic [SAMPLE_BITS-1:0]    cur_min, cur_max;
    logic [FRAME_LEN_BITS-1:0] pos_next;
    logic [FRAME_LEN_BITS-1:0] eff_len;
    logic                      frame_end;

    // A length of zero acts as one, anything above the maximum acts as the maximum.
    always_comb begin
        priority if (i_frame_length == '0) begin
            eff_len = FRAME_LEN_BITS'(1);
        end else if (i_frame_length > FRAME_LEN_MAX) begin
            eff_len = FRAME_LEN_MAX;
        end else begin
            eff_len = i_frame_length;
        end
    end

    always_comb begin
        cur_min   = (i_sample < r_min) ? i_sample : r_min;
        cur_max   = (i_sample > r_max) ? i_sample : r_max;
        pos_next  = {1'b0, r_pos} + 1'b1;
        frame_end = (pos_next >= eff_len);
        o_vpp     = cur_max - cur_min;
        o_vpp_push = i_accept && frame_end;
        n_min = r_min;
        n_max = r_max;
        n_pos = r_pos;
        if (i_accept) begin
            if (frame_end) begin
                n_min = '1;
                n_max = '0;
                n_pos = '0;
            end else begin
                n_min = cur_min;
                n_max = cur_max;
                n_pos = pos_next[FRAME_POS_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '1;
            r_max <= '0;
            r_pos <= '0;
        end else begin
            r_min <= n_min;
            r_max <= n_max;
            r_pos <= n_pos;
        end
    end

endmodule

[src/appm_back.sv]
// Back end: sums frame peak-to-peak values, divides by the frame count with a
// bit-serial restoring divider and holds the result register. Depends on appm_pkg.
module appm_back #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [appm_pkg::FRAME_CNT_BITS-1:0]  i_frame_count,
    input  appm_pkg::t_queue_stat                i_q_stat,
    input  logic [SAMPLE_BITS-1:0]               i_vpp,
    output logic                                 o_q_pop,
    input  logic                                 i_pop,
    output logic                                 o_empty,
    output logic [SAMPLE_BITS-1:0]               o_average_vpp
);
    import appm_pkg::*;

    localparam int SUM_BITS  = SAMPLE_BITS + FRAME_CNT_BITS;
    localparam int ITER_BITS = $clog2(SUM_BITS + 1);

    t_back_state               r_state, n_state;
    logic [SUM_BITS-1:0]       r_sum, n_sum;
    logic [FRAME_CNT_BITS-1:0] r_fpos, n_fpos;
    logic [SUM_BITS-1:0]       r_quo, n_quo;
    logic [FRAME_CNT_BITS-1:0] r_rem, n_rem;
    logic [FRAME_CNT_BITS-1:0] r_div, n_div;
    logic [ITER_BITS-1:0]      r_iter, n_iter;
    logic                      r_out_valid, n_out_valid;
    logic [SAMPLE_BITS-1:0]    r_out_data, n_out_data;

    logic [FRAME_CNT_BITS-1:0] eff_count;
    logic [SUM_BITS-1:0]       sum_add;
    logic [FRAME_CNT_BITS:0]   fpos_next;
    logic [FRAME_CNT_BITS:0]   rem_sh;
    logic [FRAME_CNT_BITS:0]   rem_diff;
    logic                      rem_ge;
    logic                      out_taken;
    logic [SAMPLE_BITS-1:0]    quo_sat;

    assign eff_count = (i_frame_count == '0) ? FRAME_CNT_BITS'(1) : i_frame_count;
    assign sum_add   = r_sum + SUM_BITS'(i_vpp);
    assign fpos_next = {1'b0, r_fpos} + 1'b1;
    assign rem_sh    = {r_rem, r_quo[SUM_BITS-1]};
    assign rem_diff  = rem_sh - {1'b0, r_div};
    assign rem_ge    = (rem_sh >= {1'b0, r_div});
    assign out_taken = i_pop && r_out_valid;
    assign quo_sat   = (|r_quo[SUM_BITS-1:SAMPLE_BITS]) ? '1 : r_quo[SAMPLE_BITS-1:0];

    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_fpos      = r_fpos;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_div       = r_div;
        n_iter      = r_iter;
        n_out_valid = r_out_valid && !out_taken;
        n_out_data  = r_out_data;
        o_q_pop     = 1'b0;
        unique case (r_state)
            BK_ACCUM: begin
                o_q_pop = !i_q_stat.empty;
                if (!i_q_stat.empty) begin
                    if (fpos_next >= {1'b0, eff_count}) begin
                        n_quo   = sum_add;
                        n_rem   = '0;
                        n_div   = eff_count;
                        n_iter  = '0;
                        n_sum   = '0;
                        n_fpos  = '0;
                        n_state = BK_DIVIDE;
                    end else begin
                        n_sum  = sum_add;
                        n_fpos = fpos_next[FRAME_CNT_BITS-1:0];
                    end
                end
            end
            BK_DIVIDE: begin
                n_rem  = rem_ge ? rem_diff[FRAME_CNT_BITS-1:0] : rem_sh[FRAME_CNT_BITS-1:0];
                n_quo  = {r_quo[SUM_BITS-2:0], rem_ge};
                n_iter = r_iter + 1'b1;
                if (r_iter == ITER_BITS'(SUM_BITS - 1)) begin
                    n_state = BK_HOLD;
                end
            end
            BK_HOLD: begin
                if (!r_out_valid || out_taken) begin
                    n_out_valid = 1'b1;
                    n_out_data  = quo_sat;
                    n_state     = BK_ACCUM;
                end
            end
            default: begin
                n_state = BK_ACCUM;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_ACCUM;
            r_sum       <= '0;
            r_fpos      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_fpos      <= n_fpos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_iter     <= n_iter;
        r_out_data <= n_out_data;
    end

    assign o_empty       = !r_out_valid;
    assign o_average_vpp = r_out_data;

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for averaged_peak_to_peak_meter_core.
// Depends on appm_pkg and the core; a directed plan is followed by random phases,
// and every popped average is checked against the in-bench model or a typed-in value.
module tb_top;
    import appm_pkg::*;

    localparam int SW            = 12;
    localparam int SETTLE_CYCLES = 64;   // comfortably above the back end's latency
    localparam int HOLD_CYCLES   = 400;  // long receiver stall used to fill the block
    localparam int RANDOM_ITEMS  = 200;

    logic                      i_clk;
    logic                      i_rst_n       = 1'b0;
    logic                      push          = 1'b0;
    logic                      full;
    logic [SW-1:0]             i_sample      = '0;
    logic                      empty;
    logic                      pop           = 1'b0;
    logic [SW-1:0]             o_average_vpp;
    logic                      i_cfg_valid   = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index   = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data    = '0;

    averaged_peak_to_peak_meter_core #(
        .SAMPLE_BITS(SW)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_sample     (i_sample),
        .empty        (empty),
        .pop          (pop),
        .o_average_vpp(o_average_vpp),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case a request is never accepted or an average never shows up.
    initial begin
        #5_000_000;
        $display("Timed out waiting on the meter.");
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Model of the meter. It mirrors the register file and the frame and
    // measurement state, and queues each average it predicts unless a typed row is running.
    // ------------------------------------------------------------------
    logic [FRAME_LEN_BITS-1:0] len_reg;
    logic [FRAME_CNT_BITS-1:0] cnt_reg;
    logic [SW-1:0]             frame_min;
    logic [SW-1:0]             frame_max;
    logic [FRAME_LEN_BITS-1:0] frame_fill;    // samples taken in the current frame
    logic [FRAME_CNT_BITS-1:0] frames_done;   // frames closed in the current measurement
    logic [19:0]               vpp_sum;
    logic [SW-1:0]             avg_expected[$];

    // While a directed row carries its own typed-in average, the model still
    // tracks state but its prediction is dropped in favor of the table value.
    bit typed_row = 1'b0;
    // Set while both sides should run flat out, with no idle cycles at all.
    bit calm      = 1'b0;
    // Asks the receiver process for one long stall.
    bit hold_req  = 1'b0;

    int errors        = 0;
    int averages_seen = 0;
    int samples_sent  = 0;
    int writes_done   = 0;

    task automatic meter_reset();
        len_reg     = FRAME_LEN_RST;
        cnt_reg     = FRAME_CNT_RST;
        frame_min   = '1;
        frame_max   = '0;
        frame_fill  = '0;
        frames_done = '0;
        vpp_sum     = '0;
    endtask

    // One accepted sample: update the frame extremes, close the frame when it
    // is long enough, and close the measurement after enough frames.
    task automatic meter_take_sample(input logic [SW-1:0] s);
        logic [FRAME_LEN_BITS-1:0] eff_len;
        logic [FRAME_CNT_BITS-1:0] eff_cnt;
        logic [19:0]               quotient;
        logic [SW-1:0]             avg;
        if (s < frame_min) frame_min = s;
        if (s > frame_max) frame_max = s;
        frame_fill = frame_fill + 1'b1;
        // A zero length behaves as one sample, anything past 4096 as 4096.
        if (len_reg == '0) eff_len = FRAME_LEN_BITS'(1);
        else if (len_reg > FRAME_LEN_MAX) eff_len = FRAME_LEN_MAX;
        else eff_len = len_reg;
        if (frame_fill >= eff_len) begin
            vpp_sum     = vpp_sum + 20'(frame_max) - 20'(frame_min);
            frame_min   = '1;
            frame_max   = '0;
            frame_fill  = '0;
            frames_done = frames_done + 1'b1;
            // A zero count behaves as one frame, so the divisor is never zero.
            eff_cnt = (cnt_reg == '0) ? 8'd1 : cnt_reg;
            if (frames_done >= eff_cnt) begin
                quotient = vpp_sum / 20'(eff_cnt);
                // Lowering the count mid-measurement can push the quotient past
                // the sample range; the block clamps it.
                avg = (quotient > 20'd4095) ? 12'hFFF : quotient[SW-1:0];
                vpp_sum     = '0;
                frames_done = '0;
                if (!typed_row) avg_expected.push_back(avg);
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        errors++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------
    // Request side. A sample is offered with push high and counts as taken
    // at the first edge where full was low.
    // ------------------------------------------------------------------
    task automatic feed_sample(input logic [SW-1:0] s);
        while (!calm && $urandom_range(99) < 12) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push     <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (full);
        meter_take_sample(s);
        samples_sent++;
    endtask

    // Registers may only change with no average in flight. Samples that close
    // no measurement leave nothing in the queue, so the back end is also given
    // its full latency before we touch the registers.
    task automatic settle_meter();
        push <= 1'b0;
        while (avg_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_FRAME_LENGTH: len_reg = data;
            CFG_FRAME_COUNT:  cnt_reg = data[FRAME_CNT_BITS-1:0];
            default: ;
        endcase
        writes_done++;
        // Wait with valid low so that the next write never lowers and raises valid at once.
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side. The receiver pops at random, runs flat out while calm is
    // set, and on request holds off for a long stretch so that the frame
    // queue inside the block fills and full rises.
    // ------------------------------------------------------------------
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= calm || ($urandom_range(99) >= 12);
            end
        end
    end

    // Every popped average is checked against the oldest one predicted.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            averages_seen++;
            if (avg_expected.size() == 0) begin
                report_mismatch($sformatf("average %0d popped with none expected",
                                          o_average_vpp));
            end else begin
                if (o_average_vpp !== avg_expected[0]) begin
                    report_mismatch($sformatf("average_vpp %0d, expected %0d",
                                              o_average_vpp, avg_expected[0]));
                end
                void'(avg_expected.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed plan. A burst row sends n samples alternating a, b, a, ...
    // so each full frame of two or more samples has a peak-to-peak of |a - b|.
    // A write row first waits for the block to go idle.
    // ------------------------------------------------------------------
    typedef enum logic {
        ROW_WRITE,
        ROW_BURST
    } t_row_kind;

    typedef struct {
        t_row_kind                kind;
        t_cfg_index               idx;
        logic [CFG_DATA_BITS-1:0] data;
        int                       n;
        logic [SW-1:0]            a;
        logic [SW-1:0]            b;
        bit                       typed;
        logic [SW-1:0]            avg;
    } t_plan_row;

    localparam int PLAN_ROWS = 27;

    t_plan_row plan [PLAN_ROWS] = '{
        // Reset settings: the first frame closes on exactly the 256th sample,
        // so its peak-to-peak is 3000 - 100. Then single-sample frames of zero
        // finish the measurement on the tenth frame: 2900 / 10.
        '{ROW_BURST, CFG_FRAME_LENGTH, 13'd0,    255,  12'd100,  12'd100,  1'b0, 12'd0},
        '{ROW_BURST, CFG_FRAME_LENGTH, 13'd0,    1,    12'd3000, 12'd3000, 1'b0, 12'd0},
        '{ROW_WRITE, CFG_FRAME_LENGTH, 13'd1,    0,    12'd0,    12'd0,    1'b0, 12'd0},
        '{ROW_BURST, CFG_FRAME_LENGTH, 13'd0,    9,    12'd7,    12'd7,    1'b1, 12'd290},
        // Single-sample frames, single-frame measurements: always zero.
        '{ROW_WRITE, CFG_FRAME_COUNT,  13'd1,    0,    12'd0,    12'd0,    1'b0, 12'd0},
        '{ROW_BURST, CFG_FRAME_LENGTH, 13'd0,    1,    12'd1234, 12'd1234, 1'b1, 12'd0},
        // Zero frame length behaves as one sample.
        '{ROW_WRITE, CFG_FRAME_LENGTH, 13'd0,    0,    12'd0,    12'd0,    1'b0, 12'd0},
        '{ROW_BURST, CFG_FRAME_LENGTH, 13'd0,    1,    12'd4095, 12'd4095, 1'b1, 12'd0},
        // Zero frame count behaves as one frame.
        '{ROW_WRITE, CFG_FRAME_LENGTH, 13'd2,    0,    12'd0,    12'd0,    1'b0, 12'd0},
        '{ROW_WRITE, CFG_FRAME_COUNT,  13'd0,    0,    12'd0,    12'd0,    1'b0, 12'd0},
        '{ROW_BURST, CFG_FRAME_LENGTH, 13'd0,    2,    12'd100,  12'd300,  1'b1, 12'd200},
        // Largest frame count, with single-sample frames.
        '{ROW_WRITE, CFG_FRAME_LENGTH, 13'd1,    0,    12'd0,    12'd0,    1'b0, 12'd0},
        '{ROW_WRITE, CFG_FRAME_COUNT,  13'd255,  0,    12'd0,    12'd0,    1'b0, 12'd0},
        '{ROW_BURST, CFG_FRAME_LENGTH, 13'd0,    255,  12'd0,    12'd4095, 1'b1, 12'd0},
        // Truncation: (2 + 2 + 1) / 3 gives 1.
        '{ROW_WRITE, CFG_FRAME_LENGTH, 13'd2,    0,    12'd0,    12'd0,    1'b0, 12'd0},
        '{ROW_WRITE, CFG_FRAME_COUNT,  13'd3,    0,    12'd0,    12'd0,    1'b0, 12'd0},
        '{ROW_BURST, CFG_FRAME_LENGTH, 13'd0,    2,    12'd0,    12'd2,    1'b0, 12'd0},
        '{ROW_BURST, CFG_FRAME_LENGTH, 13'd0,    2,    12'd0,    12'd2,    1'b0, 12'd0},
        '{ROW_BURST, CFG_FRAME_LENGTH, 13'd0,    2,    12'd0,    12'd1,    1'b1, 12'd1},
        // Registers changed in the middle of a measurement. The length drops
        // below the samples already in the frame, so the next sample closes it;
        // then the count drops below the frames already done, and the inflated
        // quotient is clamped to the top of the range.
        '{ROW_WRITE, CFG_FRAME_LENGTH, 13'd4,    0,    12'd0,    12'd0,    1'b0, 12'd0},
        '{ROW_WRITE, CFG_FRAME_COUNT,  13'd4,    0,    12'd0,    12'd0,    1'b0, 12'd0},
        '{ROW_BURST, CFG_FRAME_LENGTH, 13'd0,    6,    12'd10,   12'd20,   1'b0, 12'd0},
        '{ROW_WRITE, CFG_FRAME_LENGTH, 13'd2,    0,    12'd0,    12'd0,    1'b0, 12'd0},
        '{ROW_BURST, CFG_FRAME_LENGTH, 13'd0,    1,    12'd15,   12'd15,   1'b0, 12'd0},
        '{ROW_WRITE, CFG_FRAME_COUNT,  13'd1,    0,    12'd0,    12'd0,    1'b0, 12'd0},
        '{ROW_BURST, CFG_FRAME_LENGTH, 13'd0,    2,    12'd0,    12'd4095, 1'b1, 12'd4095},
        '{ROW_BURST, CFG_FRAME_LENGTH, 13'd0,    4,    12'd5,    12'd9,    1'b0, 12'd0}
    };

    // Random settings stay small most of the time so that averages come often.
    function automatic logic [CFG_DATA_BITS-1:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 70) return CFG_DATA_BITS'($urandom_range(1, 8));
        if (r < 92) return CFG_DATA_BITS'($urandom_range(9, 48));
        return '0;
    endfunction

    // Bits above the count field ride along at random; the register drops them.
    function automatic logic [CFG_DATA_BITS-1:0] pick_count();
        int r;
        logic [FRAME_CNT_BITS-1:0] c;
        r = $urandom_range(99);
        if (r < 80) c = FRAME_CNT_BITS'($urandom_range(1, 6));
        else if (r < 90) c = FRAME_CNT_BITS'($urandom_range(7, 20));
        else c = '0;
        return {5'($urandom_range(31)), c};
    endfunction

    function automatic logic [SW-1:0] pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        return SW'($urandom_range(4095));
    endfunction

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        int phase;
        int random_sent;
        int n;
        phase       = 0;
        random_sent = 0;
        meter_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_WRITE) begin
                settle_meter();
                write_reg(plan[r].idx, plan[r].data);
            end else begin
                if (plan[r].typed) avg_expected.push_back(plan[r].avg);
                typed_row = plan[r].typed;
                for (int k = 0; k < plan[r].n; k++) begin
                    feed_sample((k % 2 == 0) ? plan[r].a : plan[r].b);
                end
                typed_row = 1'b0;
            end
        end

        // Random phases. Each one usually rewrites both registers; now and then
        // only one changes, which lands in the middle of a measurement. Phase
        // one stalls the receiver while two-sample frames pour in, and phase
        // two runs a long burst with no idle cycles on either side.
        while (random_sent < RANDOM_ITEMS) begin
            settle_meter();
            calm = (phase == 2);
            if (phase == 1) begin
                write_reg(CFG_FRAME_LENGTH, 13'd2);
                write_reg(CFG_FRAME_COUNT, 13'd1);
                hold_req = 1'b1;
                n = 64;
            end else begin
                if (phase == 0 || $urandom_range(99) < 80) begin
                    write_reg(CFG_FRAME_LENGTH, pick_length());
                    write_reg(CFG_FRAME_COUNT, pick_count());
                end else if ($urandom_range(1) == 0) begin
                    write_reg(CFG_FRAME_LENGTH, pick_length());
                end else begin
                    write_reg(CFG_FRAME_COUNT, pick_count());
                end
                n = calm ? 96 : $urandom_range(8, 48);
            end
            repeat (n) feed_sample(pick_sample());
            random_sent += n;
            phase++;
        end
        calm = 1'b0;

        // Drain: all predicted averages must come out, then give the back end
        // its latency to show anything it should not.
        settle_meter();

        $display("Sent %0d samples over %0d register writes; %0d averages checked.",
                 samples_sent, writes_done, averages_seen);
        $display("Reset settings, frame lengths 0 to 48 and counts 0 to 255, "
                 , "mid-measurement writes, clamped averages and a long output stall "
                 , "were exercised.");
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[files.f]
src/appm_pkg.sv
src/appm_queue.sv
src/appm_front.sv
src/appm_back.sv
src/averaged_peak_to_peak_meter_core.sv
tb/sv/tb_top.sv
